// File: rtl/core/hop_pkg.sv
package hop_pkg;

   // one byte of the handshake message
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_type;

   // one decoded field or the closing status
   typedef struct packed {
      logic [3:0]  kind;
      logic [63:0] value;
      logic [5:0]  swarm_index;
      logic [1:0]  status;
      logic [2:0]  error_cause;
      logic [15:0] bytes_consumed;
      logic        done_res;
   } rsp_type;

   typedef enum logic [4:0] {
      PH_DEST    = 5'd0,
      PH_TYPE    = 5'd1,
      PH_SRC     = 5'd2,
      PH_OPT     = 5'd3,
      PH_VER     = 5'd4,
      PH_MINVER  = 5'd5,
      PH_SWLEN   = 5'd6,
      PH_SWBYTES = 5'd7,
      PH_CPROT   = 5'd8,
      PH_MERKLE  = 5'd9,
      PH_LIVESIG = 5'd10,
      PH_ADDR    = 5'd11,
      PH_DISC    = 5'd12,
      PH_SUPLEN  = 5'd13,
      PH_SUPSKIP = 5'd14,
      PH_CHUNK   = 5'd15,
      PH_DONE    = 5'd16
   } phase_type;

   typedef enum logic [3:0] {
      KIND_DEST    = 4'd0,
      KIND_SRC     = 4'd1,
      KIND_VER     = 4'd2,
      KIND_MINVER  = 4'd3,
      KIND_SWLEN   = 4'd4,
      KIND_SWBYTE  = 4'd5,
      KIND_CPROT   = 4'd6,
      KIND_MERKLE  = 4'd7,
      KIND_LIVESIG = 4'd8,
      KIND_ADDR    = 4'd9,
      KIND_DISC    = 4'd10,
      KIND_SUPLEN  = 4'd11,
      KIND_CHUNK   = 4'd12,
      KIND_STATUS  = 4'd13
   } kind_type;

   typedef enum logic [1:0] {
      ST_INIT  = 2'd0,
      ST_CLOSE = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CAUSE_NONE      = 3'd0,
      CAUSE_TYPE      = 3'd1,
      CAUSE_METHOD    = 3'd2,
      CAUSE_NO_END    = 3'd3,
      CAUSE_TRUNCATED = 3'd4,
      CAUSE_SWARM     = 3'd5,
      CAUSE_NOT_INIT  = 3'd6
   } cause_type;

   localparam logic [7:0] OPT_END  = 8'hff;
   localparam logic [7:0] OPT_LAST = 8'd9;
   localparam logic [7:0] MSG_TYPE_HANDSHAKE = 8'h00;

   // phase entered after option codes 0..9
   function automatic phase_type opt_phase(input logic [3:0] code);
      phase_type ph;
      case (code)
         4'd0:    ph = PH_VER;
         4'd1:    ph = PH_MINVER;
         4'd2:    ph = PH_SWLEN;
         4'd3:    ph = PH_CPROT;
         4'd4:    ph = PH_MERKLE;
         4'd5:    ph = PH_LIVESIG;
         4'd6:    ph = PH_ADDR;
         4'd7:    ph = PH_DISC;
         4'd8:    ph = PH_SUPLEN;
         4'd9:    ph = PH_CHUNK;
         default: ph = PH_OPT;
      endcase
      return ph;
   endfunction

endpackage

// File: rtl/core/handshake_option_parser.sv
// Handshake option parser.
// Requests arrive on the req_ channel, one message byte per request, with
// end_of_message set on the last byte. A request is taken on a rising edge
// with req_valid high and req_stall low.
// Results leave on the rsp_ channel: one per decoded field, one per swarm-id
// byte, and a closing status (done_res set) carrying init, close or error.
// Many bytes (padding of multi-byte fields, skipped bitmap bytes, bytes after
// a status) produce no result.
// A request is registered on entry and its result is registered on exit;
// the decode step runs on the request once the exit register can load,
// and its result enters the exit register at that edge.
// Throughput: one request per cycle unless stalled; the single-byte decode
// step is the only logic between the entry and exit registers.
// Stall: while the exit register holds an unaccepted result, the entry
// register holds its request and req_stall rises; backpressure stalls the
// incoming bytes, and nothing is dropped.
// Reset (synchronous, active high) empties both registers, returns the
// parser to the destination-channel phase and clears the kept addressing
// method and channel numbers.
module handshake_option_parser #(
   parameter int SWARM_MAX = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hop_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hop_pkg::rsp_type rsp_data
);

   // entry register
   logic             in_valid_ff, in_valid_in;
   hop_pkg::req_type in_item_ff, in_item_in;

   // exit register
   logic             rsp_valid_ff, rsp_valid_in;
   hop_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic             res_free;
   logic             step;
   logic             take;
   logic             has_result;
   hop_pkg::rsp_type result;

   hop_decode #(
      .SWARM_MAX (SWARM_MAX)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (in_item_ff),
      .has_result (has_result),
      .result     (result)
   );

   always_comb begin
      // exit register can load when empty or being drained this cycle
      res_free  = !rsp_valid_ff || !rsp_stall;
      step      = in_valid_ff && res_free;
      req_stall = in_valid_ff && !res_free;
      take      = req_valid && !req_stall;

      in_valid_in = take ? 1'b1 : (in_valid_ff && !step);
      in_item_in  = take ? req_data : in_item_ff;

      rsp_valid_in = step ? has_result : (rsp_valid_ff && rsp_stall);
      rsp_data_in  = (step && has_result) ? result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // backpressure only ever holds a request already in the entry register
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("req_stall raised with an empty entry register");

   // a decoded result always appears on the port in the following cycle
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      step && has_result |=> rsp_valid && rsp_data == $past(result))
      else $error("decoded result lost on its way to the exit register");

   // status and byte count only travel on status results
   a_status_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != hop_pkg::KIND_STATUS |->
         rsp_data.bytes_consumed == 16'd0 && rsp_data.done_res == 1'b0)
      else $error("status fields set on a field result");

endmodule

// File: rtl/core/hop_decode.sv
// Byte-wide handshake parser: state registers plus one step of decode per byte.
module hop_decode #(
   parameter int SWARM_MAX = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  hop_pkg::req_type item,
   output logic             has_result,
   output hop_pkg::rsp_type result
);

   localparam logic [16:0] SwarmLimit = 17'(SWARM_MAX);

   hop_pkg::phase_type phase_ff, phase_in;
   logic [15:0] fbl_ff, fbl_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  floor_ff, floor_in;
   logic [7:0]  method_ff, method_in;
   logic [31:0] dest_ff, dest_in;
   logic [31:0] src_ff, src_in;
   logic [15:0] count_ff, count_in;
   logic [5:0]  pos_ff, pos_in;

   logic [7:0]  b;
   logic        active;
   logic        fin;
   logic [15:0] count_inc;
   logic [63:0] shifted;
   logic [15:0] fbl_dec;
   logic        field_end;
   logic [31:0] src_new;

   function automatic hop_pkg::rsp_type mk_status(input hop_pkg::status_type st,
                                                  input hop_pkg::cause_type cause,
                                                  input logic [15:0] cnt);
      hop_pkg::rsp_type r;
      r                = '0;
      r.kind           = hop_pkg::KIND_STATUS;
      r.status         = st;
      r.error_cause    = cause;
      r.bytes_consumed = cnt;
      r.done_res       = 1'b1;
      return r;
   endfunction

   function automatic hop_pkg::rsp_type mk_field(input hop_pkg::kind_type k,
                                                 input logic [63:0] v);
      hop_pkg::rsp_type r;
      r       = '0;
      r.kind  = k;
      r.value = v;
      return r;
   endfunction

   always_comb begin
      b         = item.data_byte;
      active    = phase_ff != hop_pkg::PH_DONE;
      count_inc = (active && count_ff != 16'hffff) ? count_ff + 16'd1 : count_ff;
      shifted   = {acc_ff[55:0], b};
      fbl_dec   = (fbl_ff != 16'd0) ? fbl_ff - 16'd1 : fbl_ff;
      field_end = fbl_dec == 16'd0;
      src_new   = shifted[31:0];

      phase_in   = phase_ff;
      fbl_in     = fbl_ff;
      acc_in     = acc_ff;
      floor_in   = floor_ff;
      method_in  = method_ff;
      dest_in    = dest_ff;
      src_in     = src_ff;
      count_in   = count_inc;
      pos_in     = pos_ff;
      has_result = 1'b0;
      result     = '0;
      fin        = 1'b0;

      unique case (phase_ff)
         hop_pkg::PH_DEST: begin
            acc_in = shifted;
            if (count_inc >= 16'd4) begin
               dest_in    = shifted[31:0];
               result     = mk_field(hop_pkg::KIND_DEST, {32'd0, shifted[31:0]});
               has_result = 1'b1;
               phase_in   = hop_pkg::PH_TYPE;
            end
         end
         hop_pkg::PH_TYPE: begin
            if (b != hop_pkg::MSG_TYPE_HANDSHAKE) begin
               result     = mk_status(hop_pkg::ST_ERROR, hop_pkg::CAUSE_TYPE,
                                      count_inc - 16'd1);
               has_result = 1'b1;
               fin        = 1'b1;
            end else begin
               phase_in = hop_pkg::PH_SRC;
               fbl_in   = 16'd4;
               acc_in   = '0;
            end
         end
         hop_pkg::PH_SRC: begin
            acc_in = shifted;
            fbl_in = fbl_dec;
            if (field_end) begin
               src_in     = src_new;
               has_result = 1'b1;
               if (dest_ff != 32'd0 && src_new == 32'd0) begin
                  result = mk_status(hop_pkg::ST_CLOSE, hop_pkg::CAUSE_NONE, count_inc);
                  fin    = 1'b1;
               end else begin
                  result   = mk_field(hop_pkg::KIND_SRC, {32'd0, src_new});
                  phase_in = hop_pkg::PH_OPT;
                  floor_in = '0;
               end
            end
         end
         hop_pkg::PH_OPT: begin
            if (b == hop_pkg::OPT_END) begin
               has_result = 1'b1;
               fin        = 1'b1;
               if (dest_ff == 32'd0 && src_ff != 32'd0)
                  result = mk_status(hop_pkg::ST_INIT, hop_pkg::CAUSE_NONE, count_inc);
               else
                  result = mk_status(hop_pkg::ST_ERROR, hop_pkg::CAUSE_NOT_INIT,
                                     count_inc);
            end else if (b <= hop_pkg::OPT_LAST && b >= {4'd0, floor_ff}) begin
               floor_in = b[3:0] + 4'd1;
               phase_in = hop_pkg::opt_phase(b[3:0]);
               acc_in   = '0;
               case (hop_pkg::opt_phase(b[3:0]))
                  hop_pkg::PH_SWLEN: fbl_in = 16'd2;
                  hop_pkg::PH_CHUNK: fbl_in = 16'd4;
                  hop_pkg::PH_DISC: begin
                     if (method_ff == 8'd0 || method_ff == 8'd2) begin
                        fbl_in = 16'd4;
                     end else if (method_ff <= 8'd4) begin
                        fbl_in = 16'd8;
                     end else begin
                        result     = mk_status(hop_pkg::ST_ERROR, hop_pkg::CAUSE_METHOD,
                                               count_inc);
                        has_result = 1'b1;
                        fin        = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end else begin
               result     = mk_status(hop_pkg::ST_ERROR, hop_pkg::CAUSE_NO_END,
                                      count_inc - 16'd1);
               has_result = 1'b1;
               fin        = 1'b1;
            end
         end
         hop_pkg::PH_VER: begin
            result     = mk_field(hop_pkg::KIND_VER, {56'd0, b});
            has_result = 1'b1;
            phase_in   = hop_pkg::PH_OPT;
         end
         hop_pkg::PH_MINVER: begin
            result     = mk_field(hop_pkg::KIND_MINVER, {56'd0, b});
            has_result = 1'b1;
            phase_in   = hop_pkg::PH_OPT;
         end
         hop_pkg::PH_CPROT: begin
            result     = mk_field(hop_pkg::KIND_CPROT, {56'd0, b});
            has_result = 1'b1;
            phase_in   = hop_pkg::PH_OPT;
         end
         hop_pkg::PH_MERKLE: begin
            result     = mk_field(hop_pkg::KIND_MERKLE, {56'd0, b});
            has_result = 1'b1;
            phase_in   = hop_pkg::PH_OPT;
         end
         hop_pkg::PH_LIVESIG: begin
            result     = mk_field(hop_pkg::KIND_LIVESIG, {56'd0, b});
            has_result = 1'b1;
            phase_in   = hop_pkg::PH_OPT;
         end
         hop_pkg::PH_ADDR: begin
            method_in  = b;
            result     = mk_field(hop_pkg::KIND_ADDR, {56'd0, b});
            has_result = 1'b1;
            phase_in   = hop_pkg::PH_OPT;
         end
         hop_pkg::PH_SWLEN: begin
            acc_in = shifted;
            fbl_in = fbl_dec;
            if (field_end) begin
               has_result = 1'b1;
               if ({1'b0, shifted[15:0]} > SwarmLimit) begin
                  result = mk_status(hop_pkg::ST_ERROR, hop_pkg::CAUSE_SWARM, count_inc);
                  fin    = 1'b1;
               end else begin
                  result   = mk_field(hop_pkg::KIND_SWLEN, {48'd0, shifted[15:0]});
                  fbl_in   = shifted[15:0];
                  pos_in   = '0;
                  phase_in = (shifted[15:0] != 16'd0) ? hop_pkg::PH_SWBYTES
                                                      : hop_pkg::PH_OPT;
               end
            end
         end
         hop_pkg::PH_SWBYTES: begin
            result             = mk_field(hop_pkg::KIND_SWBYTE, {56'd0, b});
            result.swarm_index = pos_ff;
            has_result         = 1'b1;
            pos_in             = pos_ff + 6'd1;
            fbl_in             = fbl_dec;
            if (field_end)
               phase_in = hop_pkg::PH_OPT;
         end
         hop_pkg::PH_DISC: begin
            acc_in = shifted;
            fbl_in = fbl_dec;
            if (field_end) begin
               result     = mk_field(hop_pkg::KIND_DISC, shifted);
               has_result = 1'b1;
               phase_in   = hop_pkg::PH_OPT;
            end
         end
         hop_pkg::PH_SUPLEN: begin
            result     = mk_field(hop_pkg::KIND_SUPLEN, {56'd0, b});
            has_result = 1'b1;
            fbl_in     = {8'd0, b};
            phase_in   = (b != 8'd0) ? hop_pkg::PH_SUPSKIP : hop_pkg::PH_OPT;
         end
         hop_pkg::PH_SUPSKIP: begin
            fbl_in = fbl_dec;
            if (field_end)
               phase_in = hop_pkg::PH_OPT;
         end
         hop_pkg::PH_CHUNK: begin
            acc_in = shifted;
            fbl_in = fbl_dec;
            if (field_end) begin
               result     = mk_field(hop_pkg::KIND_CHUNK, {32'd0, shifted[31:0]});
               has_result = 1'b1;
               phase_in   = hop_pkg::PH_OPT;
            end
         end
         default: ;
      endcase

      if (fin)
         phase_in = hop_pkg::PH_DONE;

      if (item.end_of_message) begin
         if (active && !fin) begin
            result     = mk_status(hop_pkg::ST_ERROR, hop_pkg::CAUSE_TRUNCATED, count_inc);
            has_result = 1'b1;
         end
         phase_in = hop_pkg::PH_DEST;
         fbl_in   = '0;
         acc_in   = '0;
         floor_in = '0;
         count_in = '0;
         pos_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= hop_pkg::PH_DEST;
         fbl_ff    <= '0;
         acc_ff    <= '0;
         floor_ff  <= '0;
         method_ff <= '0;
         dest_ff   <= '0;
         src_ff    <= '0;
         count_ff  <= '0;
         pos_ff    <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         fbl_ff    <= fbl_in;
         acc_ff    <= acc_in;
         floor_ff  <= floor_in;
         method_ff <= method_in;
         dest_ff   <= dest_in;
         src_ff    <= src_in;
         count_ff  <= count_in;
         pos_ff    <= pos_in;
      end
   end

endmodule

// File: tb/tb_top.sv
module tb_top;

   localparam int SWARM_LIMIT  = 64;
   localparam int ITEM_TARGET  = 400;     // requests before the random part stops
   localparam int STEADY_FROM  = 340;     // no idling on either side from here on
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;       // two-stage pipe, plus margin
   localparam int REPORT_MAX   = 10;

   // option codes, in the order the parser demands them
   localparam logic [7:0] OPT_SWARM     = 8'd2;
   localparam logic [7:0] OPT_METHOD    = 8'd6;
   localparam logic [7:0] OPT_WINDOW    = 8'd7;
   localparam logic [7:0] OPT_SUPPORTED = 8'd8;
   localparam logic [7:0] OPT_CHUNK     = 8'd9;

   // phase the parser moves to after each option code 0..9
   localparam hop_pkg::phase_type OPTION_PHASE [10] = '{
      hop_pkg::PH_VER, hop_pkg::PH_MINVER, hop_pkg::PH_SWLEN, hop_pkg::PH_CPROT,
      hop_pkg::PH_MERKLE, hop_pkg::PH_LIVESIG, hop_pkg::PH_ADDR, hop_pkg::PH_DISC,
      hop_pkg::PH_SUPLEN, hop_pkg::PH_CHUNK};

   typedef enum {MSG_INIT, MSG_NOT_INIT, MSG_CLOSE, MSG_WRONG_TYPE,
                 MSG_BAD_OPTION, MSG_TRUNCATED, MSG_NOISE} msg_shape_type;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   hop_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   hop_pkg::rsp_type rsp_data;

   logic [7:0]   msg_bytes[$];     // the message being sent, first byte first
   int           sent_count = 0;   // requests accepted so far
   bit           steady     = 1'b0;
   int           stall_left = 0;
   int           cycles     = 0;

   handshake_option_parser #(.SWARM_MAX(SWARM_LIMIT)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // ---------------------------------------------------------------------
   // Parser state as the testbench sees it
   // ---------------------------------------------------------------------
   hop_pkg::phase_type ps_phase;
   logic [15:0] ps_left;        // bytes still owed by a multi-byte field
   logic [63:0] ps_acc;
   logic [7:0]  ps_floor;       // lowest option code still allowed
   logic [7:0]  ps_method;      // chunk addressing method, survives messages
   logic [31:0] ps_dest;
   logic [31:0] ps_src;
   logic [15:0] ps_count;
   logic [5:0]  ps_swarm_pos;

   function automatic void restart_message();
      ps_phase     = hop_pkg::PH_DEST;
      ps_left      = '0;
      ps_acc       = '0;
      ps_floor     = '0;
      ps_count     = '0;
      ps_swarm_pos = '0;
   endfunction

   // shift a byte into the accumulator; true once the field is complete
   function automatic bit take_byte(input logic [7:0] b);
      ps_acc = {ps_acc[55:0], b};
      if (ps_left != 0)
         ps_left--;
      return ps_left == 0;
   endfunction

   function automatic hop_pkg::rsp_type field_of(input hop_pkg::kind_type k,
                                                 input logic [63:0] v,
                                                 input logic [5:0] idx);
      hop_pkg::rsp_type f;
      f             = '0;
      f.kind        = k;
      f.value       = v;
      f.swarm_index = idx;
      return f;
   endfunction

   function automatic hop_pkg::rsp_type status_of(input hop_pkg::status_type st,
                                                  input hop_pkg::cause_type c,
                                                  input logic [15:0] cnt);
      hop_pkg::rsp_type f;
      f                = '0;
      f.kind           = hop_pkg::KIND_STATUS;
      f.status         = st;
      f.error_cause    = c;
      f.bytes_consumed = cnt;
      f.done_res       = 1'b1;
      return f;
   endfunction

   // Advance the parser by one request; returns 1 when it yields a result.
   function automatic bit decode_byte(input logic [7:0] b, input logic eom,
                                      output hop_pkg::rsp_type res);
      bit                got;
      bit                fin;
      bit                active;
      hop_pkg::kind_type k;
      got    = 1'b0;
      fin    = 1'b0;
      res    = '0;
      active = (ps_phase != hop_pkg::PH_DONE);
      if (active && ps_count != 16'hffff)
         ps_count++;

      case (ps_phase)
         hop_pkg::PH_DEST: begin
            ps_acc = {ps_acc[55:0], b};
            if (ps_count >= 16'd4) begin
               ps_dest  = ps_acc[31:0];
               res      = field_of(hop_pkg::KIND_DEST, 64'(ps_dest), '0);
               got      = 1'b1;
               ps_phase = hop_pkg::PH_TYPE;
            end
         end
         hop_pkg::PH_TYPE: begin
            if (b != hop_pkg::MSG_TYPE_HANDSHAKE) begin
               // count stops short of the offending type byte
               res = status_of(hop_pkg::ST_ERROR, hop_pkg::CAUSE_TYPE, ps_count - 16'd1);
               got = 1'b1;
               fin = 1'b1;
            end else begin
               ps_phase = hop_pkg::PH_SRC;
               ps_left  = 16'd4;
               ps_acc   = '0;
            end
         end
         hop_pkg::PH_SRC: begin
            if (take_byte(b)) begin
               ps_src = ps_acc[31:0];
               if (ps_dest != 0 && ps_src == 0) begin
                  // close: source channel itself is not reported
                  res = status_of(hop_pkg::ST_CLOSE, hop_pkg::CAUSE_NONE, ps_count);
                  fin = 1'b1;
               end else begin
                  res      = field_of(hop_pkg::KIND_SRC, 64'(ps_src), '0);
                  ps_phase = hop_pkg::PH_OPT;
                  ps_floor = '0;
               end
               got = 1'b1;
            end
         end
         hop_pkg::PH_OPT: begin
            if (b == hop_pkg::OPT_END) begin
               if (ps_dest == 0 && ps_src != 0)
                  res = status_of(hop_pkg::ST_INIT, hop_pkg::CAUSE_NONE, ps_count);
               else
                  res = status_of(hop_pkg::ST_ERROR, hop_pkg::CAUSE_NOT_INIT, ps_count);
               got = 1'b1;
               fin = 1'b1;
            end else if (b <= hop_pkg::OPT_LAST && b >= ps_floor) begin
               ps_floor = b + 8'd1;
               ps_phase = OPTION_PHASE[b[3:0]];
               ps_acc   = '0;
               case (ps_phase)
                  hop_pkg::PH_SWLEN: ps_left = 16'd2;
                  hop_pkg::PH_CHUNK: ps_left = 16'd4;
                  hop_pkg::PH_DISC: begin
                     // window width follows the addressing method last seen
                     if (ps_method == 8'd0 || ps_method == 8'd2) begin
                        ps_left = 16'd4;
                     end else if (ps_method <= 8'd4) begin
                        ps_left = 16'd8;
                     end else begin
                        res = status_of(hop_pkg::ST_ERROR, hop_pkg::CAUSE_METHOD,
                                        ps_count);
                        got = 1'b1;
                        fin = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end else begin
               // out of order or unknown code: not counted
               res = status_of(hop_pkg::ST_ERROR, hop_pkg::CAUSE_NO_END, ps_count - 16'd1);
               got = 1'b1;
               fin = 1'b1;
            end
         end
         hop_pkg::PH_VER, hop_pkg::PH_MINVER, hop_pkg::PH_CPROT, hop_pkg::PH_MERKLE,
         hop_pkg::PH_LIVESIG, hop_pkg::PH_ADDR: begin
            case (ps_phase)
               hop_pkg::PH_VER:     k = hop_pkg::KIND_VER;
               hop_pkg::PH_MINVER:  k = hop_pkg::KIND_MINVER;
               hop_pkg::PH_CPROT:   k = hop_pkg::KIND_CPROT;
               hop_pkg::PH_MERKLE:  k = hop_pkg::KIND_MERKLE;
               hop_pkg::PH_LIVESIG: k = hop_pkg::KIND_LIVESIG;
               default:             k = hop_pkg::KIND_ADDR;
            endcase
            if (ps_phase == hop_pkg::PH_ADDR)
               ps_method = b;
            res      = field_of(k, 64'(b), '0);
            got      = 1'b1;
            ps_phase = hop_pkg::PH_OPT;
         end
         hop_pkg::PH_SWLEN: begin
            if (take_byte(b)) begin
               if (ps_acc[15:0] > SWARM_LIMIT) begin
                  res = status_of(hop_pkg::ST_ERROR, hop_pkg::CAUSE_SWARM, ps_count);
                  fin = 1'b1;
               end else begin
                  res          = field_of(hop_pkg::KIND_SWLEN, 64'(ps_acc[15:0]), '0);
                  ps_left      = ps_acc[15:0];
                  ps_swarm_pos = '0;
                  ps_phase     = (ps_acc[15:0] != 0) ? hop_pkg::PH_SWBYTES
                                                     : hop_pkg::PH_OPT;
               end
               got = 1'b1;
            end
         end
         hop_pkg::PH_SWBYTES: begin
            res = field_of(hop_pkg::KIND_SWBYTE, 64'(b), ps_swarm_pos);
            got = 1'b1;
            ps_swarm_pos++;
            if (ps_left != 0)
               ps_left--;
            if (ps_left == 0)
               ps_phase = hop_pkg::PH_OPT;
         end
         hop_pkg::PH_DISC: begin
            if (take_byte(b)) begin
               res      = field_of(hop_pkg::KIND_DISC, ps_acc, '0);
               got      = 1'b1;
               ps_phase = hop_pkg::PH_OPT;
            end
         end
         hop_pkg::PH_SUPLEN: begin
            res      = field_of(hop_pkg::KIND_SUPLEN, 64'(b), '0);
            got      = 1'b1;
            ps_left  = {8'd0, b};
            ps_phase = (b != 0) ? hop_pkg::PH_SUPSKIP : hop_pkg::PH_OPT;
         end
         hop_pkg::PH_SUPSKIP: begin
            // bitmap bytes: counted, never reported
            if (ps_left != 0)
               ps_left--;
            if (ps_left == 0)
               ps_phase = hop_pkg::PH_OPT;
         end
         hop_pkg::PH_CHUNK: begin
            if (take_byte(b)) begin
               res      = field_of(hop_pkg::KIND_CHUNK, {32'd0, ps_acc[31:0]}, '0);
               got      = 1'b1;
               ps_phase = hop_pkg::PH_OPT;
            end
         end
         default: ;
      endcase

      if (fin)
         ps_phase = hop_pkg::PH_DONE;

      // end of message always restarts; an unfinished one reports truncation,
      // overriding whatever field this byte produced
      if (eom) begin
         if (active && !fin) begin
            res = status_of(hop_pkg::ST_ERROR, hop_pkg::CAUSE_TRUNCATED, ps_count);
            got = 1'b1;
         end
         restart_message();
      end
      return got;
   endfunction

   // Decoded fields still owed by the parser, oldest first.
   class field_tracker;
      hop_pkg::rsp_type owed_fields[$];
      int unsigned      mismatches;

      // an accepted request: predict what it yields
      function void note_request(logic [7:0] b, logic eom);
         hop_pkg::rsp_type want;
         if (decode_byte(b, eom, want))
            owed_fields.push_back(want);
      endfunction

      function int pending();
         return owed_fields.size();
      endfunction

      function void check_field(hop_pkg::rsp_type got);
         hop_pkg::rsp_type want;
         if (owed_fields.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected result: kind %0d value %h status %0d cause %0d",
                        got.kind, got.value, got.status, got.error_cause);
            return;
         end
         want = owed_fields.pop_front();
         if (got.kind !== want.kind || got.value !== want.value ||
             got.swarm_index !== want.swarm_index || got.status !== want.status ||
             got.error_cause !== want.error_cause ||
             got.bytes_consumed !== want.bytes_consumed ||
             got.done_res !== want.done_res) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
               $display("want kind %0d value %h idx %0d st %0d cause %0d cnt %0d done %b",
                        want.kind, want.value, want.swarm_index, want.status,
                        want.error_cause, want.bytes_consumed, want.done_res);
               $display("got  kind %0d value %h idx %0d st %0d cause %0d cnt %0d done %b",
                        got.kind, got.value, got.swarm_index, got.status,
                        got.error_cause, got.bytes_consumed, got.done_res);
            end
         end
      endfunction
   endclass

   field_tracker fields;

   // ---------------------------------------------------------------------
   // Message building
   // ---------------------------------------------------------------------
   function automatic void put_bytes(input logic [63:0] v, input int n);
      int i;
      for (i = n - 1; i >= 0; i--)
         msg_bytes.push_back(v[8*i +: 8]);
   endfunction

   function automatic void put_junk(input int n);
      repeat (n) msg_bytes.push_back(8'($urandom));
   endfunction

   function automatic void build_message(input msg_shape_type shape);
      logic [31:0] dest;
      logic [31:0] src;
      logic [7:0]  method;
      logic [15:0] len;
      int          code;
      int          last;
      int          bad_at;
      int          keep;
      int          r;
      msg_bytes.delete();
      if (shape == MSG_NOISE) begin
         put_junk(int'($urandom_range(1, 12)));
         return;
      end

      dest = $urandom;
      src  = $urandom;
      if (src == 0)
         src = 32'd1;
      if (dest == 0)
         dest = 32'd1;
      case (shape)
         MSG_CLOSE:      src = '0;
         MSG_WRONG_TYPE: ;
         MSG_NOT_INIT: begin
            if ($urandom_range(0, 2) == 0) begin
               dest = '0;
               src  = '0;
            end
         end
         default:        dest = '0;   // initiation, so options get parsed
      endcase
      put_bytes(64'(dest), 4);
      msg_bytes.push_back((shape == MSG_WRONG_TYPE) ? 8'($urandom_range(1, 255))
                                                    : hop_pkg::MSG_TYPE_HANDSHAKE);
      put_bytes(64'(src), 4);

      if (shape != MSG_CLOSE && shape != MSG_WRONG_TYPE) begin
         method = ps_method;
         last   = -1;
         bad_at = (shape == MSG_BAD_OPTION) ?
                  int'($urandom_range(0, hop_pkg::OPT_LAST + 1)) : -1;
         // slot OPT_LAST+1 is where the end code goes
         for (code = 0; code <= hop_pkg::OPT_LAST + 1; code++) begin
            if (code == bad_at) begin
               if (last >= 0 && $urandom_range(0, 1) == 1)
                  msg_bytes.push_back(8'($urandom_range(0, last)));
               else
                  msg_bytes.push_back(8'($urandom_range(hop_pkg::OPT_LAST + 1,
                                                        hop_pkg::OPT_END - 1)));
               break;
            end
            if (code == hop_pkg::OPT_LAST + 1) begin
               msg_bytes.push_back(hop_pkg::OPT_END);
            end else if ($urandom_range(0, 1) == 1) begin
               msg_bytes.push_back(8'(code));
               last = code;
               case (8'(code))
                  OPT_SWARM: begin
                     r = int'($urandom_range(0, 19));
                     if (r < 14)
                        len = 16'($urandom_range(0, 8));
                     else if (r < 18)
                        len = 16'($urandom_range(9, SWARM_LIMIT));
                     else if (r == 18)
                        len = 16'($urandom_range(SWARM_LIMIT, SWARM_LIMIT + 1));
                     else
                        len = 16'($urandom_range(SWARM_LIMIT + 1, 16'hffff));
                     put_bytes(64'(len), 2);
                     if (len <= SWARM_LIMIT)
                        put_junk(int'(len));
                  end
                  OPT_METHOD: begin
                     method = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 4))
                                                         : 8'($urandom);
                     msg_bytes.push_back(method);
                  end
                  OPT_WINDOW: begin
                     put_bytes({$urandom, $urandom},
                               (method == 8'd0 || method == 8'd2) ? 4 : 8);
                  end
                  OPT_SUPPORTED: begin
                     len = ($urandom_range(0, 19) != 0) ? 16'($urandom_range(0, 6))
                                                        : 16'($urandom_range(0, 255));
                     msg_bytes.push_back(len[7:0]);
                     put_junk(int'(len));
                  end
                  OPT_CHUNK: put_bytes(64'($urandom), 4);
                  default:   msg_bytes.push_back(8'($urandom));
               endcase
            end
         end
      end

      // bytes after a status are ignored until the end of message
      if ($urandom_range(0, 7) == 0)
         put_junk(int'($urandom_range(1, 4)));

      if (shape == MSG_TRUNCATED) begin
         keep = int'($urandom_range(1, msg_bytes.size() - 1));
         while (msg_bytes.size() > keep)
            void'(msg_bytes.pop_back());
      end
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   task automatic send_request(input logic [7:0] b, input logic eom);
      if (!steady && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, end_of_message: eom};
      // hold the request until an edge finds the parser not stalling
      do
         @(posedge clock);
      while (req_stall);
      fields.note_request(b, eom);
      sent_count++;
   endtask

   task automatic send_message();
      foreach (msg_bytes[i])
         send_request(msg_bytes[i], i == msg_bytes.size() - 1);
   endtask

   // ---------------------------------------------------------------------
   // Clock, watchdog, result side
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("handshake_option_parser verification failed");
         $finish;
      end
   end

   // Results are taken on the edge where valid is high and our stall is low;
   // the stall itself comes in random bursts, none during the steady tail.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         fields.check_field(rsp_data);
      if (reset || steady) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = int'($urandom_range(1, 8)) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      int            r;
      msg_shape_type shape;
      fields = new();
      restart_message();
      ps_method = '0;
      ps_dest   = '0;
      ps_src    = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // wrong type byte straight after the destination channel
      msg_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h07};
      send_message();
      // close: all-ones destination, zero source
      msg_bytes = '{8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_message();
      // message cut after its first byte
      msg_bytes = '{8'hff};
      send_message();
      // initiation with an eight-byte discard window of all ones
      msg_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff,
                    OPT_METHOD, 8'h01, OPT_WINDOW, 8'hff, 8'hff, 8'hff, 8'hff,
                    8'hff, 8'hff, 8'hff, 8'hff, hop_pkg::OPT_END};
      send_message();

      // random part: mostly well-formed handshakes with random content
      while (sent_count < ITEM_TARGET) begin
         if (sent_count >= STEADY_FROM)
            steady = 1'b1;
         r = int'($urandom_range(0, 99));
         if (r < 45)
            shape = MSG_INIT;
         else if (r < 55)
            shape = MSG_NOT_INIT;
         else if (r < 63)
            shape = MSG_CLOSE;
         else if (r < 68)
            shape = MSG_WRONG_TYPE;
         else if (r < 80)
            shape = MSG_BAD_OPTION;
         else if (r < 92)
            shape = MSG_TRUNCATED;
         else
            shape = MSG_NOISE;
         build_message(shape);
         send_message();
      end
      req_valid <= 1'b0;

      while (fields.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fields.mismatches == 0 && fields.pending() == 0)
         $display("handshake_option_parser verification clean");
      else
         $display("handshake_option_parser verification failed");
      $finish;
   end

endmodule

// File: handshake_option_parser.f
rtl/core/hop_pkg.sv
rtl/core/hop_decode.sv
rtl/core/handshake_option_parser.sv
tb/tb_top.sv
